// ===== rtl/nlp_pkg.sv =====
package nlp_pkg;

   localparam int MAX_DEGREE = 63;
   localparam int FRAC_BITS  = 30;
   localparam int WORK_BITS  = 48;

   localparam int VAL_W = 65;
   localparam int RAT_W = 14;
   localparam int DVD_W = RAT_W + WORK_BITS;
   localparam int RAD_W = 64 + WORK_BITS;
   localparam int ROOT_W = RAD_W / 2;

   typedef logic signed [VAL_W-1:0] val_type;

   localparam val_type ONE_W = val_type'(1) <<< WORK_BITS;
   localparam logic [63:0] SAT_MAG = 64'd1 << 62;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_OMX, ST_DIAG_DIV, ST_DIAG_MUL1, ST_DIAG_MUL2, ST_DIAG_TEST,
      ST_SCALE_DIV, ST_SCALE_MUL, ST_P0_SQRT, ST_C23_SQRT, ST_P1_MUL1, ST_P1_MUL2,
      ST_REC_TEST, ST_REC_FDIV, ST_REC_FSQRT, ST_REC_IDIV, ST_REC_ISQRT,
      ST_REC_MUL1, ST_REC_MUL2, ST_REC_MUL3, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {OP_NONE, OP_MUL, OP_SQRT, OP_DIV} op_type;

   typedef enum logic [3:0] {
      SRC_X, SRC_OMX2, SRC_PROD, SRC_P0, SRC_P1, SRC_T, SRC_FCT, SRC_INV, SRC_DIFF, SRC_C23
   } src_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_T, DST_A, DST_FCT, DST_INV, DST_PROD, DST_P1, DST_OMX2, DST_P0, DST_SHIFT
   } dst_type;

   typedef enum logic [1:0] {RAT_DIAG, RAT_SCALE, RAT_FCT, RAT_INV} rat_type;

   typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_K} cnt_type;

   typedef struct packed {
      logic    load;
      logic    start;
      op_type  op;
      src_type src_a;
      src_type src_b;
      dst_type dst;
      rat_type rat;
      cnt_type cnt;
      logic    emit;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic err;
      logic m_zero;
      logic n_eq_m;
      logic cnt_le_m;
      logic cnt_le_n;
      logic done;
   } stat_type;

endpackage

// ===== rtl/normalized_legendre_pnm.sv =====
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   req_tdata: degree, order, arg_x
// rsp      out  rsp_tvalid/rsp_tready   rsp_tdata: value; rsp_tuser: status
//
// One request at a time. A diagonal step is one divide, two multiplies and one test; a
// recurrence step is two divides, two square roots, three multiplies and one test.
// A request runs m diagonal steps and then n-m-1 recurrence steps; with n equal to m
// no recurrence step runs, and a rejected request goes straight to its result.
// A result not taken holds the block in its last state; the next request is taken
// while the previous result waits. Reset is synchronous; no clearing pass.
module normalized_legendre_pnm import nlp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // degree[5:0], order[11:6], arg_x[43:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // value[35:0]
   output logic [0:0]  rsp_tuser    // status[0]
);

   cmd_type  cmd;
   stat_type st;

   nlp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .st         (st),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   nlp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/nlp_mul.sv =====
module nlp_mul import nlp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  val_type a,
   input  val_type b,
   output logic    done,
   output val_type result
);

   localparam int SAT_BIT = 62 + WORK_BITS;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [63:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic         neg_ff, neg_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   sh_ff, sh_in;
   logic [127:0] acc_ff, acc_in;
   val_type      res_ff, res_in;

   logic [127:0] pp_sh;
   logic [127:0] rnd;
   logic [63:0]  mag;
   logic [31:0]  fa, fb;

   always_comb begin
      fa = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      fb = (cnt_ff[1:0] == 2'd1 || cnt_ff[1:0] == 2'd3) ? mb_ff[63:32] : mb_ff[31:0];
      case (sh_ff)
         2'd0:    pp_sh = 128'(pp_ff);
         2'd3:    pp_sh = 128'(pp_ff) << 64;
         default: pp_sh = 128'(pp_ff) << 32;
      endcase
      rnd = acc_ff + (128'd1 << (WORK_BITS - 1));
      if (|rnd[127:SAT_BIT]) begin
         mag = SAT_MAG;
      end else begin
         mag = 64'(rnd[SAT_BIT-1:WORK_BITS]);
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      pp_in   = pp_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         acc_in  = '0;
         ma_in   = a[VAL_W-1] ? 64'(-a) : 64'(a);
         mb_in   = b[VAL_W-1] ? 64'(-b) : 64'(b);
         neg_in  = a[VAL_W-1] ^ b[VAL_W-1];
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff < 3'd4) begin
            pp_in = fa * fb;
            sh_in = cnt_ff[1:0];
         end
         if (cnt_ff != 3'd0 && cnt_ff < 3'd5) begin
            acc_in = acc_ff + pp_sh;
         end
         if (cnt_ff == 3'd5) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -val_type'(mag) : val_type'(mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== rtl/nlp_sqrt.sv =====
module nlp_sqrt import nlp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  val_type v,
   output logic    done,
   output val_type result
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;

   logic [ROOT_W+2:0] cur, trial, diff;
   logic              ge;

   always_comb begin
      cur   = {rem_ff, rad_ff[RAD_W-1:RAD_W-2]};
      trial = {1'b0, root_ff, 2'b01};
      diff  = cur - trial;
      ge    = cur >= trial;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         root_in = '0;
         if (v > 0) begin
            rad_in = RAD_W'(v[63:0]) << WORK_BITS;
         end else begin
            rad_in = '0;
         end
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = ge ? diff[ROOT_W:0] : cur[ROOT_W:0];
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff + 6'd1;
         if (cnt_ff == 6'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done   = done_ff;
   assign result = val_type'(root_ff);

endmodule

// ===== rtl/nlp_div.sv =====
module nlp_div import nlp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RAT_W-1:0] num,
   input  logic [RAT_W-1:0] den,
   output logic             done,
   output val_type          result
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVD_W-1:0] q_ff, q_in;
   logic [RAT_W-1:0] rem_ff, rem_in;
   logic [RAT_W-1:0] den_ff, den_in;

   logic [RAT_W:0] cur, diff;
   logic           ge;

   always_comb begin
      cur  = {rem_ff, dvd_ff[DVD_W-1]};
      diff = cur - {1'b0, den_ff};
      ge   = cur >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = '0;
         den_in  = den;
         dvd_in  = (DVD_W'(num) << WORK_BITS) + DVD_W'(den >> 1);
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         rem_in = ge ? diff[RAT_W-1:0] : cur[RAT_W-1:0];
         q_in   = {q_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done   = done_ff;
   assign result = val_type'(q_ff);

endmodule

// ===== rtl/nlp_datapath.sv =====
module nlp_datapath import nlp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tready,
   output stat_type    st,
   output logic        rsp_tvalid,
   output logic [39:0] rsp_tdata,
   output logic [0:0]  rsp_tuser
);

   localparam int SH  = WORK_BITS - FRAC_BITS;
   localparam int SHP = (SH > 0) ? SH : 0;
   localparam int SHN = (SH < 0) ? -SH : 0;
   localparam logic [63:0] ONE_F = 64'd1 << FRAC_BITS;
   localparam logic [63:0] RNDX  = (64'd1 << SHN) >> 1;
   localparam logic [63:0] RNDO  = (64'd1 << SHP) >> 1;
   localparam logic [63:0] POS_MAX = (64'd1 << 35) - 64'd1;
   localparam logic [63:0] NEG_MAX = 64'd1 << 35;

   logic [5:0]  n_ff, n_in, m_ff, m_in;
   logic        err_ff, err_in;
   logic [6:0]  cnt_ff, cnt_in;
   val_type     x_ff, x_in, omx2_ff, omx2_in, prod_ff, prod_in;
   val_type     p0_ff, p0_in, p1_ff, p1_in, t_ff, t_in;
   val_type     a_ff, a_in, fct_ff, fct_in, inv_ff, inv_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [35:0] rsp_value_ff, rsp_value_in;
   logic        rsp_status_ff, rsp_status_in;

   logic [31:0] xr;
   logic [32:0] xm33;
   logic [63:0] xm, xs;
   val_type     x_load;

   val_type     opa, opb, res;
   logic [RAT_W-1:0] num, den;
   logic [5:0]  k, km;
   logic [11:0] ksq, kmsq, msq;

   logic        mul_done, sqrt_done, div_done, any_done;
   val_type     mul_res, sqrt_res, div_res;

   logic [63:0] omag, orr;
   logic        oneg;

   function automatic val_type pick(input src_type s, input val_type x, input val_type omx2,
                                    input val_type prod, input val_type p0, input val_type p1,
                                    input val_type t, input val_type fct, input val_type inv,
                                    input val_type a, input logic [5:0] m);
      val_type r;
      case (s)
         SRC_X:    r = x;
         SRC_OMX2: r = omx2;
         SRC_PROD: r = prod;
         SRC_P0:   r = p0;
         SRC_P1:   r = p1;
         SRC_T:    r = t;
         SRC_FCT:  r = fct;
         SRC_INV:  r = inv;
         SRC_DIFF: r = a - t;
         SRC_C23:  r = val_type'({m, 1'b0} + 7'd3) <<< WORK_BITS;
         default:  r = '0;
      endcase
      return r;
   endfunction

   always_comb begin
      opa = pick(cmd.src_a, x_ff, omx2_ff, prod_ff, p0_ff, p1_ff, t_ff, fct_ff, inv_ff,
                 a_ff, m_ff);
      opb = pick(cmd.src_b, x_ff, omx2_ff, prod_ff, p0_ff, p1_ff, t_ff, fct_ff, inv_ff,
                 a_ff, m_ff);

      k    = cnt_ff[5:0];
      km   = k - 6'd1;
      ksq  = k * k;
      kmsq = km * km;
      msq  = m_ff * m_ff;
      case (cmd.rat)
         RAT_DIAG: begin
            num = RAT_W'({k, 1'b0}) - RAT_W'(1);
            den = RAT_W'({k, 1'b0});
         end
         RAT_SCALE: begin
            num = RAT_W'({m_ff, 1'b1});
            den = RAT_W'(2);
         end
         RAT_FCT: begin
            num = (RAT_W'(ksq) << 2) - RAT_W'(1);
            den = RAT_W'(ksq) - RAT_W'(msq);
         end
         default: begin
            num = RAT_W'(kmsq) - RAT_W'(msq);
            den = (RAT_W'(kmsq) << 2) - RAT_W'(1);
         end
      endcase
   end

   nlp_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start && cmd.op == OP_MUL),
      .a      (opa),
      .b      (opb),
      .done   (mul_done),
      .result (mul_res)
   );

   nlp_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start && cmd.op == OP_SQRT),
      .v      (opa),
      .done   (sqrt_done),
      .result (sqrt_res)
   );

   nlp_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start && cmd.op == OP_DIV),
      .num    (num),
      .den    (den),
      .done   (div_done),
      .result (div_res)
   );

   always_comb begin
      any_done = mul_done | sqrt_done | div_done;
      case (cmd.op)
         OP_MUL:  res = mul_res;
         OP_SQRT: res = sqrt_res;
         OP_DIV:  res = div_res;
         default: res = '0;
      endcase

      xr   = req_tdata[43:12];
      xm33 = xr[31] ? (33'h1_0000_0000 - {1'b0, xr}) : {1'b0, xr};
      xm   = 64'(xm33);
      if (xm > ONE_F) begin
         xm = ONE_F;
      end
      xs = ((xm << SHP) + RNDX) >> SHN;
      x_load = xr[31] ? -val_type'(xs) : val_type'(xs);

      oneg = opa[VAL_W-1];
      omag = oneg ? 64'(-opa) : 64'(opa);
      orr  = (omag + RNDO) >> SHP;
      if (orr > (SAT_MAG >> SHN)) begin
         orr = SAT_MAG;
      end else begin
         orr = orr << SHN;
      end
      if (oneg) begin
         if (orr > NEG_MAX) begin
            orr = NEG_MAX;
         end
         orr = 64'd0 - orr;
      end else if (orr > POS_MAX) begin
         orr = POS_MAX;
      end
   end

   always_comb begin
      n_in    = n_ff;
      m_in    = m_ff;
      err_in  = err_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      omx2_in = omx2_ff;
      prod_in = prod_ff;
      p0_in   = p0_ff;
      p1_in   = p1_ff;
      t_in    = t_ff;
      a_in    = a_ff;
      fct_in  = fct_ff;
      inv_in  = inv_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.load) begin
         n_in    = req_tdata[5:0];
         m_in    = req_tdata[11:6];
         err_in  = (req_tdata[11:6] > req_tdata[5:0]) ||
                   ({2'b00, req_tdata[5:0]} > 8'(MAX_DEGREE));
         x_in    = x_load;
         prod_in = ONE_W;
         cnt_in  = 7'd1;
      end

      case (cmd.cnt)
         CNT_INC: cnt_in = cnt_ff + 7'd1;
         CNT_K:   cnt_in = {1'b0, m_ff} + 7'd2;
         default: ;
      endcase

      if (any_done) begin
         case (cmd.dst)
            DST_T:    t_in    = res;
            DST_A:    a_in    = res;
            DST_FCT:  fct_in  = res;
            DST_INV:  inv_in  = res;
            DST_PROD: prod_in = res;
            DST_P1:   p1_in   = res;
            DST_OMX2: omx2_in = ONE_W - res;
            DST_P0:   p0_in   = m_ff[0] ? -res : res;
            DST_SHIFT: begin
               p0_in = p1_ff;
               p1_in = res;
            end
            default: ;
         endcase
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (err_ff) begin
            rsp_value_in  = '0;
            rsp_status_in = 1'b1;
         end else begin
            rsp_value_in  = orr[35:0];
            rsp_status_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      m_ff          <= m_in;
      err_ff        <= err_in;
      cnt_ff        <= cnt_in;
      x_ff          <= x_in;
      omx2_ff       <= omx2_in;
      prod_ff       <= prod_in;
      p0_ff         <= p0_in;
      p1_ff         <= p1_in;
      t_ff          <= t_in;
      a_ff          <= a_in;
      fct_ff        <= fct_in;
      inv_ff        <= inv_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      st.rsp_free = !rsp_valid_ff || rsp_tready;
      st.err      = err_ff;
      st.m_zero   = m_ff == 6'd0;
      st.n_eq_m   = n_ff == m_ff;
      st.cnt_le_m = cnt_ff <= {1'b0, m_ff};
      st.cnt_le_n = cnt_ff <= {1'b0, n_ff};
      st.done     = any_done;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== rtl/nlp_ctrl.sv =====
module nlp_ctrl import nlp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  stat_type st,
   output logic     req_tready,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      issued_ff, issued_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.op     = OP_NONE;
      cmd.src_a  = SRC_X;
      cmd.src_b  = SRC_X;
      cmd.dst    = DST_NONE;
      cmd.rat    = RAT_DIAG;
      cmd.cnt    = CNT_HOLD;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (cmd.load) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (st.err) begin
               state_in = ST_EMIT;
            end else if (st.m_zero) begin
               state_in = ST_SCALE_DIV;
            end else begin
               state_in = ST_OMX;
            end
         end
         ST_OMX: begin
            cmd.op = OP_MUL; cmd.src_a = SRC_X; cmd.src_b = SRC_X; cmd.dst = DST_OMX2;
            if (st.done) state_in = ST_DIAG_DIV;
         end
         ST_DIAG_DIV: begin
            cmd.op = OP_DIV; cmd.rat = RAT_DIAG; cmd.dst = DST_T;
            if (st.done) state_in = ST_DIAG_MUL1;
         end
         ST_DIAG_MUL1: begin
            cmd.op = OP_MUL; cmd.src_a = SRC_OMX2; cmd.src_b = SRC_T; cmd.dst = DST_T;
            if (st.done) state_in = ST_DIAG_MUL2;
         end
         ST_DIAG_MUL2: begin
            cmd.op = OP_MUL; cmd.src_a = SRC_PROD; cmd.src_b = SRC_T; cmd.dst = DST_PROD;
            if (st.done) begin
               cmd.cnt  = CNT_INC;
               state_in = ST_DIAG_TEST;
            end
         end
         ST_DIAG_TEST: begin
            state_in = st.cnt_le_m ? ST_DIAG_DIV : ST_SCALE_DIV;
         end
         ST_SCALE_DIV: begin
            cmd.op = OP_DIV; cmd.rat = RAT_SCALE; cmd.dst = DST_T;
            if (st.done) state_in = ST_SCALE_MUL;
         end
         ST_SCALE_MUL: begin
            cmd.op = OP_MUL; cmd.src_a = SRC_PROD; cmd.src_b = SRC_T; cmd.dst = DST_T;
            if (st.done) state_in = ST_P0_SQRT;
         end
         ST_P0_SQRT: begin
            cmd.op = OP_SQRT; cmd.src_a = SRC_T; cmd.dst = DST_P0;
            if (st.done) state_in = st.n_eq_m ? ST_EMIT : ST_C23_SQRT;
         end
         ST_C23_SQRT: begin
            cmd.op = OP_SQRT; cmd.src_a = SRC_C23; cmd.dst = DST_T;
            if (st.done) state_in = ST_P1_MUL1;
         end
         ST_P1_MUL1: begin
            cmd.op = OP_MUL; cmd.src_a = SRC_X; cmd.src_b = SRC_T; cmd.dst = DST_T;
            if (st.done) state_in = ST_P1_MUL2;
         end
         ST_P1_MUL2: begin
            cmd.op = OP_MUL; cmd.src_a = SRC_T; cmd.src_b = SRC_P0; cmd.dst = DST_P1;
            if (st.done) begin
               cmd.cnt  = CNT_K;
               state_in = ST_REC_TEST;
            end
         end
         ST_REC_TEST: begin
            state_in = st.cnt_le_n ? ST_REC_FDIV : ST_EMIT;
         end
         ST_REC_FDIV: begin
            cmd.op = OP_DIV; cmd.rat = RAT_FCT; cmd.dst = DST_T;
            if (st.done) state_in = ST_REC_FSQRT;
         end
         ST_REC_FSQRT: begin
            cmd.op = OP_SQRT; cmd.src_a = SRC_T; cmd.dst = DST_FCT;
            if (st.done) state_in = ST_REC_IDIV;
         end
         ST_REC_IDIV: begin
            cmd.op = OP_DIV; cmd.rat = RAT_INV; cmd.dst = DST_T;
            if (st.done) state_in = ST_REC_ISQRT;
         end
         ST_REC_ISQRT: begin
            cmd.op = OP_SQRT; cmd.src_a = SRC_T; cmd.dst = DST_INV;
            if (st.done) state_in = ST_REC_MUL1;
         end
         ST_REC_MUL1: begin
            cmd.op = OP_MUL; cmd.src_a = SRC_X; cmd.src_b = SRC_P1; cmd.dst = DST_A;
            if (st.done) state_in = ST_REC_MUL2;
         end
         ST_REC_MUL2: begin
            cmd.op = OP_MUL; cmd.src_a = SRC_P0; cmd.src_b = SRC_INV; cmd.dst = DST_T;
            if (st.done) state_in = ST_REC_MUL3;
         end
         ST_REC_MUL3: begin
            cmd.op = OP_MUL; cmd.src_a = SRC_DIFF; cmd.src_b = SRC_FCT; cmd.dst = DST_SHIFT;
            if (st.done) begin
               cmd.cnt  = CNT_INC;
               state_in = ST_REC_TEST;
            end
         end
         ST_EMIT: begin
            cmd.emit  = st.rsp_free;
            cmd.src_a = st.n_eq_m ? SRC_P0 : SRC_P1;
            if (st.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      cmd.start = (cmd.op != OP_NONE) && !issued_ff;
      issued_in = (cmd.op != OP_NONE) && !st.done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
   end

endmodule

// ===== tb/tb.sv =====
module tb;
   import nlp_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // degree[5:0], order[11:6], arg_x[43:12]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // value[35:0]
   logic [0:0]  rsp_tuser;   // status[0]

   typedef struct packed {
      logic [35:0] value;
      logic        status;
   } pnm_result_type;

   logic [47:0]     pending_reqs[$];
   pnm_result_type  expected_pnm[$];
   int              accepted_cnt;
   int              err_cnt;
   int              send_idle_pct;
   int              recv_idle_pct;

   localparam logic [63:0] SAT = 64'd1 << 62;

   normalized_legendre_pnm i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   function automatic logic [63:0] mag64(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint q_mul(longint a, longint b);
      logic [127:0] p;
      logic [63:0]  mag;
      bit           ng;
      ng = (a < 0) != (b < 0);
      p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
      p = p + (128'd1 << 47);
      if (p >= (128'd1 << 110)) mag = SAT;
      else mag = p[111:48];
      if (mag > SAT) mag = SAT;
      return ng ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint q_sqrt(longint v);
      logic [127:0] rad;
      logic [127:0] t;
      logic [63:0]  r;
      if (v <= 0) return 0;
      rad = {64'd0, mag64(v)} << 48;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         t = {64'd0, r | (64'd1 << b)};
         if (t * t <= rad) r = r | (64'd1 << b);
      end
      return longint'(r);
   endfunction

   function automatic longint q_ratio(longint p, longint q);
      return ((p << 48) + (q >>> 1)) / q;
   endfunction

   function automatic pnm_result_type legendre_pnm(logic [47:0] d);
      pnm_result_type o;
      longint      n, m, k, km, x, prod, omx2, p0, p1, pk, fct, inv, res;
      logic [63:0] xm, mag;
      logic [31:0] xr;
      bit          xneg;
      n = d[5:0];
      m = d[11:6];
      xr = d[43:12];
      if (m > n || n > MAX_DEGREE) begin
         o.value = 0;
         o.status = 1;
         return o;
      end
      xneg = xr[31];
      xm = xneg ? (64'd1 << 32) - xr : {32'd0, xr};
      if (xm > (64'd1 << 30)) xm = 64'd1 << 30;
      xm = xm << 18;
      x = xneg ? -longint'(xm) : longint'(xm);
      prod = longint'(1) << 48;
      if (m > 0) begin
         omx2 = (longint'(1) << 48) - q_mul(x, x);
         for (longint i = 1; i <= m; i++)
            prod = q_mul(prod, q_mul(omx2, q_ratio(2*i-1, 2*i)));
      end
      p0 = q_sqrt(q_mul(prod, q_ratio(2*m+1, 2)));
      if (m[0]) p0 = -p0;
      if (n == m) begin
         res = p0;
      end else begin
         p1 = q_mul(q_mul(x, q_sqrt((2*m+3) << 48)), p0);
         for (k = m + 2; k <= n; k++) begin
            km = k - 1;
            fct = q_sqrt(q_ratio(4*k*k-1, k*k-m*m));
            inv = q_sqrt(q_ratio(km*km-m*m, 4*km*km-1));
            pk = q_mul(q_mul(x, p1) - q_mul(p0, inv), fct);
            p0 = p1;
            p1 = pk;
         end
         res = p1;
      end
      mag = (mag64(res) + (64'd1 << 17)) >> 18;
      if (res < 0) begin
         if (mag > (64'd1 << 35)) mag = 64'd1 << 35;
         o.value = 36'(-mag);
      end else begin
         if (mag > (64'd1 << 35) - 1) mag = (64'd1 << 35) - 1;
         o.value = mag[35:0];
      end
      o.status = 0;
      return o;
   endfunction

   function automatic logic [47:0] pack_req(int n, int m, logic [31:0] x);
      return {4'd0, x, 6'(m), 6'(n)};
   endfunction

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always_comb begin
      if (accepted_cnt < 50) begin
         send_idle_pct = 13; recv_idle_pct = 65;
      end else if (accepted_cnt < 100) begin
         send_idle_pct = 65; recv_idle_pct = 13;
      end else begin
         send_idle_pct = 0; recv_idle_pct = 0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1;
            req_tdata <= pending_reqs.pop_front();
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      pnm_result_type e;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
         if (req_tvalid && req_tready) begin
            expected_pnm.push_back(legendre_pnm(req_tdata));
            accepted_cnt <= accepted_cnt + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pnm.size() == 0) begin
               $display("%0t: unexpected result value=%h status=%b",
                        $time, rsp_tdata[35:0], rsp_tuser[0]);
               err_cnt <= err_cnt + 1;
            end else begin
               e = expected_pnm.pop_front();
               if (rsp_tdata[35:0] !== e.value || rsp_tuser[0] !== e.status) begin
                  $display("%0t: mismatch expected value=%h status=%b actual value=%h status=%b",
                           $time, e.value, e.status, rsp_tdata[35:0], rsp_tuser[0]);
                  err_cnt <= err_cnt + 1;
               end
            end
         end
      end
   end

   initial begin
      int n, m, r;
      logic [31:0] x;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      rsp_tready = 0;
      accepted_cnt = 0;
      err_cnt = 0;
      // directed: corners of degree, order and argument, rejects, clamping
      pending_reqs.push_back(pack_req(0, 0, 32'h0));
      pending_reqs.push_back(pack_req(0, 0, 32'h40000000));
      pending_reqs.push_back(pack_req(1, 0, 32'hC0000000));
      pending_reqs.push_back(pack_req(1, 1, 32'h20000000));
      pending_reqs.push_back(pack_req(5, 3, 32'h7FFFFFFF));
      pending_reqs.push_back(pack_req(5, 2, 32'h80000000));
      pending_reqs.push_back(pack_req(4, 5, 32'h12345678));
      pending_reqs.push_back(pack_req(0, 63, 32'h0));
      pending_reqs.push_back(pack_req(62, 63, 32'hFFFFFFFF));
      pending_reqs.push_back(pack_req(63, 0, 32'h1A000000));
      pending_reqs.push_back(pack_req(63, 63, 32'h10000000));
      pending_reqs.push_back(pack_req(63, 62, 32'hF0000001));
      pending_reqs.push_back(pack_req(3, 0, 32'h00000001));
      pending_reqs.push_back(pack_req(3, 1, 32'hFFFFFFFF));
      pending_reqs.push_back(pack_req(8, 4, 32'h3FFFFFFF));
      pending_reqs.push_back(pack_req(8, 4, 32'hC0000001));
      pending_reqs.push_back(pack_req(2, 2, 32'h40000001));
      pending_reqs.push_back(pack_req(6, 0, 32'hBFFFFFFF));
      for (int i = 0; i < 135; i++) begin
         r = $urandom_range(99);
         if (r < 80) begin
            n = $urandom_range(12);
            m = $urandom_range(n);
         end else if (r < 90) begin
            n = $urandom_range(63);
            m = $urandom_range(63 - n > 0 ? n : n) ;
            if ($urandom_range(1)) m = n - $urandom_range(n < 4 ? n : 4);
         end else begin
            n = $urandom_range(62);
            m = $urandom_range(63, n + 1);
         end
         r = $urandom_range(9);
         if (r < 7) x = $urandom_range(32'h80000000) - 32'h40000000;
         else if (r < 9) x = $urandom;
         else x = $urandom_range(1) ? 32'h40000000 : 32'hC0000000;
         pending_reqs.push_back(pack_req(n, m, x));
      end
      repeat (2) @(posedge clock);
      reset <= 0;
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_pnm.size() != 0);
      repeat (50) @(posedge clock);
      if (err_cnt == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #80000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/nlp_pkg.sv
rtl/nlp_mul.sv
rtl/nlp_sqrt.sv
rtl/nlp_div.sv
rtl/nlp_datapath.sv
rtl/nlp_ctrl.sv
rtl/normalized_legendre_pnm.sv
tb/tb.sv
